// ----- src/pcvx_pkg.sv -----
// shared types and constants for the polygon convexity test
`default_nettype none

package pcvx_pkg;

    // default coordinate width
    localparam int COORD_WIDTH_DEF = 16;

    // vertex counter, saturates at SEEN_SAT, past the point where the closing products become possible
    localparam int SEEN_W = 3;
    localparam logic [SEEN_W-1:0] SEEN_V0  = 3'd0;
    localparam logic [SEEN_W-1:0] SEEN_V1  = 3'd1;
    localparam logic [SEEN_W-1:0] SEEN_V2  = 3'd2;
    localparam logic [SEEN_W-1:0] SEEN_V3  = 3'd3;
    localparam logic [SEEN_W-1:0] SEEN_SAT = 3'd4;

    // per-beat control that rides along with the captured vertices
    typedef struct packed {
        logic last;        // final vertex of the polygon
        logic has_main;    // triple older, newer, current is valid
        logic main_first;  // that triple is v0, v1, v2
        logic closing;     // the two wrap-around triples are valid
    } vtx_ctrl_t;

endpackage

`default_nettype wire

// ----- src/pcvx_front.sv -----
// vertex tracking and input register: captures the points of up to three triples
`default_nettype none

module pcvx_front #(
    parameter int COORD_WIDTH = pcvx_pkg::COORD_WIDTH_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_x,
    input  wire signed [COORD_WIDTH-1:0]  s_vert_y,
    input  wire                           s_final_vertex,
    input  wire                           st2_ready,
    output logic                          st1_valid,
    output pcvx_pkg::vtx_ctrl_t           st1_ctrl,
    output logic signed [COORD_WIDTH-1:0] old_x,
    output logic signed [COORD_WIDTH-1:0] old_y,
    output logic signed [COORD_WIDTH-1:0] new_x,
    output logic signed [COORD_WIDTH-1:0] new_y,
    output logic signed [COORD_WIDTH-1:0] cur_x,
    output logic signed [COORD_WIDTH-1:0] cur_y,
    output logic signed [COORD_WIDTH-1:0] v0_x,
    output logic signed [COORD_WIDTH-1:0] v0_y,
    output logic signed [COORD_WIDTH-1:0] v1_x,
    output logic signed [COORD_WIDTH-1:0] v1_y
);
    import pcvx_pkg::*;

    logic [SEEN_W-1:0]             seen_reg, seen_next;
    logic signed [COORD_WIDTH-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_WIDTH-1:0] second_x_reg, second_y_reg;
    logic signed [COORD_WIDTH-1:0] older_x_reg, older_y_reg;
    logic signed [COORD_WIDTH-1:0] newer_x_reg, newer_y_reg;
    logic                          valid1_reg, valid1_next;
    vtx_ctrl_t                     ctrl1_reg, ctrl1_next;
    logic signed [COORD_WIDTH-1:0] p_old_x_reg, p_old_y_reg;
    logic signed [COORD_WIDTH-1:0] p_new_x_reg, p_new_y_reg;
    logic signed [COORD_WIDTH-1:0] p_cur_x_reg, p_cur_y_reg;
    logic signed [COORD_WIDTH-1:0] p_v0_x_reg, p_v0_y_reg;
    logic signed [COORD_WIDTH-1:0] p_v1_x_reg, p_v1_y_reg;
    logic                          accept;
    logic                          past_two;

    // input register frees up whenever the product stage takes its beat
    assign s_ready  = !valid1_reg || st2_ready;
    assign accept   = s_valid && s_ready;
    assign past_two = (seen_reg != SEEN_V0) && (seen_reg != SEEN_V1);

    // control for the captured beat
    always_comb begin
        ctrl1_next.last       = s_final_vertex;
        ctrl1_next.has_main   = past_two;
        ctrl1_next.main_first = (seen_reg == SEEN_V2);
        ctrl1_next.closing    = s_final_vertex && past_two && (seen_reg != SEEN_V2);
    end

    // vertex counter, cleared by the final vertex
    always_comb begin
        seen_next = seen_reg;
        if (accept) begin
            if (s_final_vertex) begin
                seen_next = SEEN_V0;
            end else if (seen_reg != SEEN_SAT) begin
                seen_next = seen_reg + SEEN_W'(1);
            end
        end
    end

    always_comb begin
        valid1_next = valid1_reg;
        if (accept) begin
            valid1_next = 1'b1;
        end else if (st2_ready) begin
            valid1_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg   <= SEEN_V0;
            valid1_reg <= 1'b0;
            ctrl1_reg  <= '0;
        end else begin
            seen_reg   <= seen_next;
            valid1_reg <= valid1_next;
            if (accept) begin
                ctrl1_reg <= ctrl1_next;
            end
        end
    end

    // vertex history and captured points
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (seen_reg == SEEN_V0) begin
                first_x_reg <= s_vert_x;
                first_y_reg <= s_vert_y;
            end
            if (seen_reg == SEEN_V1) begin
                second_x_reg <= s_vert_x;
                second_y_reg <= s_vert_y;
            end
            older_x_reg <= newer_x_reg;
            older_y_reg <= newer_y_reg;
            newer_x_reg <= s_vert_x;
            newer_y_reg <= s_vert_y;
            p_old_x_reg <= older_x_reg;
            p_old_y_reg <= older_y_reg;
            p_new_x_reg <= newer_x_reg;
            p_new_y_reg <= newer_y_reg;
            p_cur_x_reg <= s_vert_x;
            p_cur_y_reg <= s_vert_y;
            p_v0_x_reg  <= first_x_reg;
            p_v0_y_reg  <= first_y_reg;
            p_v1_x_reg  <= second_x_reg;
            p_v1_y_reg  <= second_y_reg;
        end
    end

    assign st1_valid = valid1_reg;
    assign st1_ctrl  = ctrl1_reg;
    assign old_x     = p_old_x_reg;
    assign old_y     = p_old_y_reg;
    assign new_x     = p_new_x_reg;
    assign new_y     = p_new_y_reg;
    assign cur_x     = p_cur_x_reg;
    assign cur_y     = p_cur_y_reg;
    assign v0_x      = p_v0_x_reg;
    assign v0_y      = p_v0_y_reg;
    assign v1_x      = p_v1_x_reg;
    assign v1_y      = p_v1_y_reg;

endmodule

`default_nettype wire

// ----- src/pcvx_cross.sv -----
// one cross product: edge differences and the two registered partial products
`default_nettype none

module pcvx_cross #(
    parameter int COORD_WIDTH = pcvx_pkg::COORD_WIDTH_DEF
) (
    input  wire                               aclk,
    input  wire                               load,
    input  wire signed [COORD_WIDTH-1:0]      px,
    input  wire signed [COORD_WIDTH-1:0]      py,
    input  wire signed [COORD_WIDTH-1:0]      qx,
    input  wire signed [COORD_WIDTH-1:0]      qy,
    input  wire signed [COORD_WIDTH-1:0]      rx,
    input  wire signed [COORD_WIDTH-1:0]      ry,
    output logic signed [2*COORD_WIDTH+1:0]   prod_l,
    output logic signed [2*COORD_WIDTH+1:0]   prod_r
);
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] ax, ay, bx, by;
    logic signed [PW-1:0] prod_l_reg, prod_l_next;
    logic signed [PW-1:0] prod_r_reg, prod_r_next;

    // a = r - q, b = p - q, exact at one extra bit
    assign ax = DW'(rx) - DW'(qx);
    assign ay = DW'(ry) - DW'(qy);
    assign bx = DW'(px) - DW'(qx);
    assign by = DW'(py) - DW'(qy);

    // product is positive exactly when ax*by exceeds ay*bx
    assign prod_l_next = PW'(ax) * PW'(by);
    assign prod_r_next = PW'(ay) * PW'(bx);

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
        end
    end

    assign prod_l = prod_l_reg;
    assign prod_r = prod_r_reg;

endmodule

`default_nettype wire

// ----- src/pcvx_judge.sv -----
// sign comparison, mismatch tracking and result register
`default_nettype none

module pcvx_judge #(
    parameter int COORD_WIDTH = pcvx_pkg::COORD_WIDTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              st1_valid,
    input  pcvx_pkg::vtx_ctrl_t              st1_ctrl,
    output logic                             st2_ready,
    output logic                             st2_load,
    input  wire signed [2*COORD_WIDTH+1:0]   main_l,
    input  wire signed [2*COORD_WIDTH+1:0]   main_r,
    input  wire signed [2*COORD_WIDTH+1:0]   wrap_a_l,
    input  wire signed [2*COORD_WIDTH+1:0]   wrap_a_r,
    input  wire signed [2*COORD_WIDTH+1:0]   wrap_b_l,
    input  wire signed [2*COORD_WIDTH+1:0]   wrap_b_r,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_is_convex
);
    import pcvx_pkg::*;

    logic      valid2_reg, valid2_next;
    vtx_ctrl_t ctrl2_reg;
    logic      first_sign_reg, first_sign_next;
    logic      mismatch_reg, mismatch_next;
    logic      m_valid_reg, m_valid_next;
    logic      convex_reg, convex_next;
    logic      out_free, advance2;
    logic      pos_main, pos_a, pos_b;

    // product stage moves on unless a final beat meets a full result register that is not being taken
    assign out_free  = !m_valid_reg || m_ready;
    assign advance2  = valid2_reg && (!ctrl2_reg.last || out_free);
    assign st2_ready = !valid2_reg || advance2;
    assign st2_load  = st1_valid && st2_ready;

    // strictly positive cross products
    assign pos_main = main_l > main_r;
    assign pos_a    = wrap_a_l > wrap_a_r;
    assign pos_b    = wrap_b_l > wrap_b_r;

    // sign agreement for the beat leaving the product stage
    always_comb begin
        first_sign_next = first_sign_reg;
        mismatch_next   = mismatch_reg;
        convex_next     = convex_reg;
        if (advance2) begin
            if (ctrl2_reg.has_main) begin
                if (ctrl2_reg.main_first) begin
                    first_sign_next = pos_main;
                end else if (pos_main != first_sign_reg) begin
                    mismatch_next = 1'b1;
                end
            end
            if (ctrl2_reg.closing) begin
                if ((pos_a != first_sign_next) || (pos_b != first_sign_next)) begin
                    mismatch_next = 1'b1;
                end
            end
            if (ctrl2_reg.last) begin
                convex_next     = ctrl2_reg.closing ? !mismatch_next : 1'b1;
                first_sign_next = 1'b0;
                mismatch_next   = 1'b0;
            end
        end
    end

    always_comb begin
        valid2_next = valid2_reg;
        if (st2_load) begin
            valid2_next = 1'b1;
        end else if (advance2) begin
            valid2_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance2 && ctrl2_reg.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg     <= 1'b0;
            ctrl2_reg      <= '0;
            first_sign_reg <= 1'b0;
            mismatch_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            valid2_reg     <= valid2_next;
            first_sign_reg <= first_sign_next;
            mismatch_reg   <= mismatch_next;
            m_valid_reg    <= m_valid_next;
            if (st2_load) begin
                ctrl2_reg <= st1_ctrl;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        convex_reg <= convex_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_is_convex = convex_reg;

endmodule

`default_nettype wire

// ----- src/polygon_convexity_test.sv -----
// polygon convexity test by cross product signs, top level
// one vertex beat accepted per cycle unless a stalled result holds the pipeline, with no gaps between polygons
// the result appears on m_valid once the final vertex has moved through all of the pipeline
// the pipeline is input register, product register, result register
// reset is synchronous and active low: clears valids, vertex count and sign flags
`default_nettype none

module polygon_convexity_test #(
    parameter int COORD_WIDTH = pcvx_pkg::COORD_WIDTH_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire signed [COORD_WIDTH-1:0] s_vert_x,
    input  wire signed [COORD_WIDTH-1:0] s_vert_y,
    input  wire                          s_final_vertex,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_is_convex
);
    import pcvx_pkg::*;

    localparam int PW = 2 * COORD_WIDTH + 2;

    logic                          st1_valid, st2_ready, st2_load;
    vtx_ctrl_t                     st1_ctrl;
    logic signed [COORD_WIDTH-1:0] old_x, old_y, new_x, new_y, cur_x, cur_y;
    logic signed [COORD_WIDTH-1:0] v0_x, v0_y, v1_x, v1_y;
    logic signed [PW-1:0]          main_l, main_r, wrap_a_l, wrap_a_r;
    logic signed [PW-1:0]          wrap_b_l, wrap_b_r;

    // vertex history and input register
    pcvx_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_vert_x       (s_vert_x),
        .s_vert_y       (s_vert_y),
        .s_final_vertex (s_final_vertex),
        .st2_ready      (st2_ready),
        .st1_valid      (st1_valid),
        .st1_ctrl       (st1_ctrl),
        .old_x          (old_x),
        .old_y          (old_y),
        .new_x          (new_x),
        .new_y          (new_y),
        .cur_x          (cur_x),
        .cur_y          (cur_y),
        .v0_x           (v0_x),
        .v0_y           (v0_y),
        .v1_x           (v1_x),
        .v1_y           (v1_y)
    );

    // running triple: older, newer, current
    pcvx_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_main (
        .aclk   (aclk),
        .load   (st2_load),
        .px     (old_x),
        .py     (old_y),
        .qx     (new_x),
        .qy     (new_y),
        .rx     (cur_x),
        .ry     (cur_y),
        .prod_l (main_l),
        .prod_r (main_r)
    );

    // wrap-around triple: newer, current, v0
    pcvx_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_wrap_a (
        .aclk   (aclk),
        .load   (st2_load),
        .px     (new_x),
        .py     (new_y),
        .qx     (cur_x),
        .qy     (cur_y),
        .rx     (v0_x),
        .ry     (v0_y),
        .prod_l (wrap_a_l),
        .prod_r (wrap_a_r)
    );

    // wrap-around triple: current, v0, v1
    pcvx_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_wrap_b (
        .aclk   (aclk),
        .load   (st2_load),
        .px     (cur_x),
        .py     (cur_y),
        .qx     (v0_x),
        .qy     (v0_y),
        .rx     (v1_x),
        .ry     (v1_y),
        .prod_l (wrap_b_l),
        .prod_r (wrap_b_r)
    );

    // sign tracking and result register
    pcvx_judge #(.COORD_WIDTH(COORD_WIDTH)) u_judge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .st1_valid   (st1_valid),
        .st1_ctrl    (st1_ctrl),
        .st2_ready   (st2_ready),
        .st2_load    (st2_load),
        .main_l      (main_l),
        .main_r      (main_r),
        .wrap_a_l    (wrap_a_l),
        .wrap_a_r    (wrap_a_r),
        .wrap_b_l    (wrap_b_l),
        .wrap_b_r    (wrap_b_r),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_convex (m_is_convex)
    );

endmodule

`default_nettype wire

// ----- src/pcvx_checker.sv -----
// port-level checks for the convexity test, bound to the top level
`default_nettype none

module pcvx_checker (
    input wire aclk,
    input wire aresetn,
    input wire s_valid,
    input wire s_ready,
    input wire s_final_vertex,
    input wire m_valid,
    input wire m_ready,
    input wire m_is_convex
);
    logic [2:0] pending_reg, pending_next;
    logic       fin_in, res_out;

    // final vertices taken but not yet answered
    assign fin_in  = s_valid && s_ready && s_final_vertex;
    assign res_out = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (fin_in && !res_out) begin
            pending_next = pending_reg + 3'd1;
        end else if (res_out && !fin_in) begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 3'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_convex))
        else $error("result beat changed while stalled");

    // no result without a final vertex behind it
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("result beat without a final vertex");

    // at most three polygons in flight
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd3)
        else $error("too many polygons in flight");

    // nothing can block the input while no polygon is waiting for its answer
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 3'd0 |-> s_ready)
        else $error("input stalled with no result pending");

endmodule

bind polygon_convexity_test pcvx_checker u_pcvx_checker (.*);

`default_nettype wire
